>>> design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants and types for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int POS_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 4;
  localparam int STAT_W      = 2;

  typedef logic [OP_W-1:0]               opcode_t;
  typedef logic [POS_W-1:0]              pos_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [POS_W-1:0]       found_t;
  typedef logic [STAT_W-1:0]             status_t;

  localparam opcode_t OP_PUSH_FRONT = 4'd0;
  localparam opcode_t OP_PUSH_BACK  = 4'd1;
  localparam opcode_t OP_POP_FRONT  = 4'd2;
  localparam opcode_t OP_POP_BACK   = 4'd3;
  localparam opcode_t OP_INSERT     = 4'd4;
  localparam opcode_t OP_REMOVE     = 4'd5;
  localparam opcode_t OP_READ       = 4'd6;
  localparam opcode_t OP_SEARCH     = 4'd7;
  localparam opcode_t OP_CLEAR      = 4'd8;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BADPOS = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

  localparam pos_t   COUNT_FULL = POS_W'(CAPACITY);
  localparam found_t FOUND_NONE = '1;

endpackage

>>> design/ple_if.sv
// ----------------------------------------------------------------------------
// ple_in_if / ple_out_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface ple_in_if;
  logic             valid;
  logic             ready;
  ple_pkg::opcode_t opcode;
  ple_pkg::pos_t    position;
  ple_pkg::value_t  value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface ple_out_if;
  logic              valid;
  logic              ready;
  ple_pkg::value_t   result_value;
  ple_pkg::found_t   found_position;
  ple_pkg::pos_t     element_count;
  ple_pkg::status_t  status;

  modport source (output valid, result_value, found_position, element_count, status,
                  input ready);
  modport sink   (input valid, result_value, found_position, element_count, status,
                  output ready);
endinterface

>>> design/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list of signed values kept in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  dir  word fields
//  in_ch    in   opcode, position, value
//  out_ch   out  result_value, found_position, element_count, status
//
//  Insert and pushes move the (count - pos) entries at and above pos up;
//  remove and pops read the entry at pos and shift those above it down;
//  read fetches one entry, search scans all count entries, and all others
//  go straight to S_FIN; the walk moves one entry per cycle through the single RAM read and write port.
//  Synchronous active-low reset clears the count; RAM contents are not reset.
//  A new word is taken while the previous result waits on out_ch; a finished
//  word then holds in S_FIN until that result leaves.
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
  input  logic       clk,
  input  logic       rst_n,
  ple_in_if.sink     in_ch,
  ple_out_if.source  out_ch
);
  import ple_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SHUP = 3'd1;
  localparam logic [2:0] S_SHDN = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  value_t mem [CAPACITY];
  value_t rd_data_r;

  logic [2:0] state_r, state_nxt;
  pos_t       count_r, count_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;

  opcode_t op_r, op_nxt;
  pos_t    mv_r, mv_nxt;
  addr_t   rd_idx_r, rd_idx_nxt;
  addr_t   wr_idx_r, wr_idx_nxt;
  addr_t   pos_r, pos_nxt;
  value_t  val_r, val_nxt;
  logic    first_r, first_nxt;
  logic    pend_first_r, pend_first_nxt;
  logic    hit_r, hit_nxt;
  value_t  res_r, res_nxt;
  found_t  found_r, found_nxt;
  status_t stat_r, stat_nxt;

  value_t  out_value_r;
  found_t  out_found_r;
  pos_t    out_count_r;
  status_t out_stat_r;
  logic    load_out;

  logic   rd_en, wr_en;
  addr_t  rd_addr, wr_addr;
  value_t wr_data;
  pos_t   tgt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    mv_nxt         = mv_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    first_nxt      = first_r;
    pend_first_nxt = pend_first_r;
    hit_nxt        = hit_r;
    res_nxt        = res_r;
    found_nxt      = found_r;
    stat_nxt       = stat_r;
    load_out       = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    rd_addr        = rd_idx_r;
    wr_addr        = wr_idx_r;
    wr_data        = rd_data_r;
    tgt            = in_ch.position;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          val_nxt   = in_ch.value;
          res_nxt   = '0;
          found_nxt = FOUND_NONE;
          stat_nxt  = ST_OK;
          pend_nxt  = 1'b0;
          first_nxt = 1'b1;
          hit_nxt   = 1'b0;
          state_nxt = S_FIN;
          case (in_ch.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
              if (in_ch.opcode == OP_PUSH_FRONT) begin
                tgt = '0;
              end else if (in_ch.opcode == OP_PUSH_BACK) begin
                tgt = count_r;
              end
              if (in_ch.opcode == OP_INSERT && in_ch.position > count_r) begin
                stat_nxt = ST_BADPOS;
              end else if (count_r >= COUNT_FULL) begin
                stat_nxt = ST_FULL;
              end else begin
                pos_nxt    = tgt[ADDR_W-1:0];
                mv_nxt     = count_r - tgt;
                rd_idx_nxt = ADDR_W'(count_r - POS_W'(1));
                state_nxt  = S_SHUP;
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE, OP_READ: begin
              if (in_ch.opcode == OP_POP_FRONT) begin
                tgt = '0;
              end else if (in_ch.opcode == OP_POP_BACK) begin
                tgt = count_r - POS_W'(1);
              end
              if ((in_ch.opcode == OP_POP_FRONT || in_ch.opcode == OP_POP_BACK) &&
                  count_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else if (tgt >= count_r) begin
                stat_nxt = ST_BADPOS;
              end else begin
                mv_nxt     = (in_ch.opcode == OP_READ) ? POS_W'(1) : count_r - tgt;
                rd_idx_nxt = tgt[ADDR_W-1:0];
                state_nxt  = S_SHDN;
              end
            end
            OP_SEARCH: begin
              mv_nxt     = count_r;
              rd_idx_nxt = '0;
              state_nxt  = S_SRCH;
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SHUP: begin
        if (pend_r) begin
          wr_en = 1'b1;
        end
        if (mv_r != '0) begin
          rd_en      = 1'b1;
          pend_nxt   = 1'b1;
          wr_idx_nxt = rd_idx_r + ADDR_W'(1);
          rd_idx_nxt = rd_idx_r - ADDR_W'(1);
          mv_nxt     = mv_r - POS_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            wr_en     = 1'b1;
            wr_addr   = pos_r;
            wr_data   = val_r;
            count_nxt = count_r + POS_W'(1);
            state_nxt = S_FIN;
          end
        end
      end

      S_SHDN: begin
        if (pend_r) begin
          if (pend_first_r) begin
            res_nxt = rd_data_r;
          end else if (op_r != OP_READ) begin
            wr_en = 1'b1;
          end
        end
        if (mv_r != '0) begin
          rd_en          = 1'b1;
          pend_nxt       = 1'b1;
          pend_first_nxt = first_r;
          first_nxt      = 1'b0;
          wr_idx_nxt     = rd_idx_r - ADDR_W'(1);
          rd_idx_nxt     = rd_idx_r + ADDR_W'(1);
          mv_nxt         = mv_r - POS_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (op_r != OP_READ) begin
              count_nxt = count_r - POS_W'(1);
            end
            state_nxt = S_FIN;
          end
        end
      end

      S_SRCH: begin
        if (pend_r && !hit_r && rd_data_r == val_r) begin
          hit_nxt   = 1'b1;
          found_nxt = found_t'({1'b0, wr_idx_r});
        end
        if (mv_r != '0) begin
          rd_en      = 1'b1;
          pend_nxt   = 1'b1;
          wr_idx_nxt = rd_idx_r;
          rd_idx_nxt = rd_idx_r + ADDR_W'(1);
          mv_nxt     = mv_r - POS_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    mv_r         <= mv_nxt;
    rd_idx_r     <= rd_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    first_r      <= first_nxt;
    pend_first_r <= pend_first_nxt;
    hit_r        <= hit_nxt;
    res_r        <= res_nxt;
    found_r      <= found_nxt;
    stat_r       <= stat_nxt;
    if (load_out) begin
      out_value_r <= res_r;
      out_found_r <= found_r;
      out_count_r <= count_r;
      out_stat_r  <= stat_r;
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = out_value_r;
  assign out_ch.found_position = out_found_r;
  assign out_ch.element_count  = out_count_r;
  assign out_ch.status         = out_stat_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + POS_W'(1) || count_r == $past(count_r) - POS_W'(1) ||
       count_r == '0))
    else $error("entry count moved by more than one");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en && rd_addr == wr_addr))
    else $error("read and write to the same entry in one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("sequencer idle right after accepting a word");

  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_FIN) |-> (mv_r <= COUNT_FULL))
    else $error("walk length above capacity");

endmodule
